// ===== sv/lr3d_pkg.sv =====
// ============================================================================
// lr3d_pkg: shared types and constants for the 3D Laplace relaxation block
// Opcodes, label codes, register indexes, the sequencer state type and
// the control structs that pass between the top level and its units.
// ============================================================================
package lr3d_pkg;

    // Default voxel store depth
    localparam int MAX_VOXELS_DEF = 32768;

    // Fixed field widths
    localparam int OPW      = 2;
    localparam int IDXW     = 15;
    localparam int LBLW     = 2;
    localparam int VALW     = 16;
    localparam int CFGW     = 16;
    localparam int CFG_IDXW = 3;

    // Six Q2.14 values summed exactly need three more bits
    localparam int SUMW  = VALW + 3;
    // Sum times unsigned Q0.16 weight (weight carried as 17-bit signed)
    localparam int PRODW = SUMW + CFGW + 1;
    localparam int FRACW = 16;

    // Opcodes
    localparam logic [OPW-1:0] OP_LOAD = 2'd0;
    localparam logic [OPW-1:0] OP_RUN  = 2'd1;
    localparam logic [OPW-1:0] OP_READ = 2'd2;

    // Voxel labels
    localparam logic [LBLW-1:0] LBL_INNER   = 2'd0;
    localparam logic [LBLW-1:0] LBL_OUTER   = 2'd1;
    localparam logic [LBLW-1:0] LBL_DOMAIN  = 2'd2;
    localparam logic [LBLW-1:0] LBL_OUTSIDE = 2'd3;

    // Register indexes
    localparam logic [CFG_IDXW-1:0] REG_SIZE_X      = 3'd0;
    localparam logic [CFG_IDXW-1:0] REG_SIZE_Y      = 3'd1;
    localparam logic [CFG_IDXW-1:0] REG_SIZE_Z      = 3'd2;
    localparam logic [CFG_IDXW-1:0] REG_SWEEP_COUNT = 3'd3;
    localparam logic [CFG_IDXW-1:0] REG_WEIGHT      = 3'd4;

    // Register reset values
    localparam logic [CFGW-1:0] SIZE_RST   = 16'd32;
    localparam logic [CFGW-1:0] SWEEP_RST  = 16'd100;
    localparam logic [CFGW-1:0] WEIGHT_RST = 16'd10923;

    // Result kinds
    localparam logic RK_READ = 1'b0;
    localparam logic RK_DONE = 1'b1;

    // Q2.14 constants
    localparam logic signed [VALW-1:0] Q_ONE     = 16'sd16384;
    localparam logic signed [VALW-1:0] Q_NEG_ONE = -16'sd16384;
    localparam logic signed [VALW-1:0] Q_MAX     = 16'sd32767;
    localparam logic signed [VALW-1:0] Q_MIN     = -16'sd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDATA,
        ST_SIZE_XY,
        ST_SIZE_XYZ,
        ST_TOTAL,
        ST_STRIDE,
        ST_LABEL,
        ST_CHECK,
        ST_NBR,
        ST_DRAIN,
        ST_MUL,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Store port strobes
    typedef struct packed {
        logic lbl_we;
        logic lbl_re;
        logic val_we;
        logic val_re;
    } st_ctl_t;

    // Weighting unit strobes
    typedef struct packed {
        logic clear;
        logic add;
        logic mul;
    } wctl_t;

    // Start value that a label gives a voxel
    function automatic logic signed [VALW-1:0] start_value(input logic [LBLW-1:0] lbl);
        logic signed [VALW-1:0] v;
        begin
            v = '0;
            if (lbl == LBL_OUTER)
            begin
                v = Q_ONE;
            end
            else if (lbl == LBL_OUTSIDE)
            begin
                v = Q_NEG_ONE;
            end
            return v;
        end
    endfunction

endpackage

// ===== sv/lr3d_store.sv =====
// ============================================================================
// lr3d_store: label and value memories
// Two single-port memories with registered read data; read data holds
// until the next read of the same memory.
// ============================================================================
module lr3d_store
    import lr3d_pkg::*;
#(
    parameter int MAX_VOXELS = MAX_VOXELS_DEF,
    parameter int AW         = $clog2(MAX_VOXELS)
)
(
    input  logic                   clk,
    input  st_ctl_t                ctl,
    input  logic [AW-1:0]          lbl_addr,
    input  logic [LBLW-1:0]        lbl_wdata,
    output logic [LBLW-1:0]        lbl_rdata,
    input  logic [AW-1:0]          val_addr,
    input  logic signed [VALW-1:0] val_wdata,
    output logic signed [VALW-1:0] val_rdata
);

    logic [LBLW-1:0]        lbl_mem [MAX_VOXELS];
    logic signed [VALW-1:0] val_mem [MAX_VOXELS];
    logic [LBLW-1:0]        lbl_rdata_reg;
    logic signed [VALW-1:0] val_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.lbl_we)
        begin
            lbl_mem[lbl_addr] <= lbl_wdata;
        end
        if (ctl.lbl_re)
        begin
            lbl_rdata_reg <= lbl_mem[lbl_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.val_we)
        begin
            val_mem[val_addr] <= val_wdata;
        end
        if (ctl.val_re)
        begin
            val_rdata_reg <= val_mem[val_addr];
        end
    end

    assign lbl_rdata = lbl_rdata_reg;
    assign val_rdata = val_rdata_reg;

endmodule

// ===== sv/lr3d_weigh.sv =====
// ============================================================================
// lr3d_weigh: shared accumulate / weight / round unit
// Sums neighbor values one per cycle, multiplies by the weight in a
// registered step, then rounds half up and saturates to Q2.14.
// ============================================================================
module lr3d_weigh
    import lr3d_pkg::*;
(
    input  logic                   clk,
    input  wctl_t                  ctl,
    input  logic signed [VALW-1:0] operand,
    input  logic [CFGW-1:0]        weight,
    output logic signed [VALW-1:0] result
);

    logic signed [SUMW-1:0]    acc_reg;
    logic signed [PRODW-1:0]   prod_reg;
    logic signed [CFGW:0]      wt_s;
    logic signed [PRODW:0]     rnd;
    logic signed [PRODW-FRACW:0] quo;

    assign wt_s = $signed({1'b0, weight});

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctl.add)
        begin
            acc_reg <= acc_reg + SUMW'(operand);
        end
        if (ctl.mul)
        begin
            prod_reg <= acc_reg * wt_s;
        end
    end

    // floor((p + 2^15) / 2^16), then clamp
    always_comb
    begin
        rnd = (PRODW+1)'(prod_reg) + (PRODW+1)'(32768);
        quo = rnd[PRODW:FRACW];
        if (quo > (PRODW-FRACW+1)'(Q_MAX))
        begin
            result = Q_MAX;
        end
        else if (quo < (PRODW-FRACW+1)'(Q_MIN))
        begin
            result = Q_MIN;
        end
        else
        begin
            result = quo[VALW-1:0];
        end
    end

endmodule

// ===== sv/laplace_relaxation_3d_top.sv =====
// ============================================================================
// laplace_relaxation_3d_top: Gauss-Seidel 3D Laplace relaxation engine
// In-place seven-point relaxation over a labelled voxel volume held in
// on-chip memory, with load, run and read commands.
// ============================================================================
//
//  Channel  Signals                                        Direction
//  -------  ---------------------------------------------  ---------
//  in       in_valid/in_ready, opcode, voxel_index,        to block
//           voxel_label
//  out      out_valid/out_ready, result_kind,              from block
//           result_index, potential
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data       to block
//
//  Sequence: a load is written from IDLE; a read goes through RDATA to the output
//  register. A run passes SIZE_XY, SIZE_XYZ, TOTAL, STRIDE; each sweep visits
//  LABEL, CHECK per voxel, and for domain voxels NBR (six neighbor reads one
//  per cycle via the single value memory port), DRAIN, MUL, WRITE; DONE posts.
//  Reset: async active-low; clears control and config registers only. The
//  memories are not cleared; every voxel must be loaded before use.
//  Stalls: in_ready is high only while idle; a finished result waits in the
//  output register, and the sequencer holds until that register is free.
//  cfg_ready is always high; config must be written only while the block
//  is idle, and the block itself does not enforce this.
module laplace_relaxation_3d_top
    import lr3d_pkg::*;
#(
    parameter int MAX_VOXELS = MAX_VOXELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input transfers
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OPW-1:0]         opcode,
    input  logic [IDXW-1:0]        voxel_index,
    input  logic [LBLW-1:0]        voxel_label,
    // result transfers
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   result_kind,
    output logic [IDXW-1:0]        result_index,
    output logic signed [VALW-1:0] potential,
    // config writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDXW-1:0]    cfg_index,
    input  logic [CFGW-1:0]        cfg_data
);

    localparam int AW = $clog2(MAX_VOXELS);     // voxel address
    localparam int TW = $clog2(MAX_VOXELS + 1); // voxel count, holds MAX_VOXELS
    localparam int VW = 3 * CFGW;               // full volume product

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [CFGW-1:0]        size_x_reg, size_x_next;
    logic [CFGW-1:0]        size_y_reg, size_y_next;
    logic [CFGW-1:0]        size_z_reg, size_z_next;
    logic [CFGW-1:0]        sweeps_reg, sweeps_next;
    logic [CFGW-1:0]        weight_reg, weight_next;
    logic [2*CFGW-1:0]      sxy_reg, sxy_next;
    logic [VW-1:0]          vol_reg, vol_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [TW-1:0]          stride_reg [3];
    logic [TW-1:0]          stride_next [3];
    logic [AW-1:0]          i_reg, i_next;
    logic [2:0]             k_reg, k_next;
    logic [CFGW-1:0]        sweep_reg, sweep_next;
    logic                   pend_reg, pend_next;
    logic [IDXW-1:0]        rd_idx_reg, rd_idx_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   kind_reg, kind_next;
    logic [IDXW-1:0]        ridx_reg, ridx_next;
    logic signed [VALW-1:0] pot_reg, pot_next;

    // ---------------------------------------------------------------------
    // Unit connections
    // ---------------------------------------------------------------------
    st_ctl_t                st_ctl;
    wctl_t                  w_ctl;
    logic [AW-1:0]          lbl_addr;
    logic [LBLW-1:0]        lbl_rdata;
    logic [AW-1:0]          val_addr;
    logic signed [VALW-1:0] val_wdata;
    logic signed [VALW-1:0] val_rdata;
    logic signed [VALW-1:0] w_result;

    // ---------------------------------------------------------------------
    // Helper logic
    // ---------------------------------------------------------------------
    logic                   in_xfer;
    logic                   idx_ok;
    logic [AW-1:0]          in_addr;
    logic                   out_free;
    logic [TW-1:0]          i_ext;
    logic [TW-1:0]          nb_stride;
    logic [TW:0]            nb_sum;
    logic [TW-1:0]          nb_diff;
    logic                   nb_ok;
    logic [AW-1:0]          nb_addr;
    logic [AW-1:0]          i_start;
    state_t                 adv_state;
    logic [AW-1:0]          adv_i;
    logic [CFGW-1:0]        adv_sweep;
    logic [TW-1:0]          tot_new;

    assign in_xfer  = in_valid && in_ready;
    assign idx_ok   = 32'(voxel_index) < 32'(MAX_VOXELS);
    assign in_addr  = AW'(voxel_index);
    assign out_free = !out_valid_reg || out_ready;

    // Neighbor k: stride k[2:1], even k looks down, odd k looks up.
    // Strides are capped at total; a capped stride fails both bounds tests.
    assign i_ext     = TW'(i_reg);
    assign nb_stride = stride_reg[k_reg[2:1]];
    assign nb_sum    = (TW+1)'(i_ext) + (TW+1)'(nb_stride);
    assign nb_diff   = i_ext - nb_stride;
    assign nb_ok     = k_reg[0] ? ((nb_stride < total_reg) &&
                                   (nb_sum < (TW+1)'(total_reg)))
                                : (nb_stride <= i_ext);
    assign nb_addr   = k_reg[0] ? AW'(nb_sum) : AW'(nb_diff);

    // Sweep starts one below the top index
    assign i_start = AW'(total_reg - TW'(2));

    // Volume capped at the store depth
    assign tot_new = (vol_reg > VW'(MAX_VOXELS)) ? TW'(MAX_VOXELS) : TW'(vol_reg);

    // Move to the next voxel, or the next sweep, or finish
    always_comb
    begin
        adv_i     = i_reg - AW'(1);
        adv_sweep = sweep_reg;
        adv_state = ST_LABEL;
        if (i_reg == '0)
        begin
            adv_sweep = sweep_reg + CFGW'(1);
            adv_i     = i_start;
            if (adv_sweep == sweeps_reg)
            begin
                adv_state = ST_DONE;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state and strobes
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        size_x_next    = size_x_reg;
        size_y_next    = size_y_reg;
        size_z_next    = size_z_reg;
        sweeps_next    = sweeps_reg;
        weight_next    = weight_reg;
        sxy_next       = sxy_reg;
        vol_next       = vol_reg;
        total_next     = total_reg;
        stride_next    = stride_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        sweep_next     = sweep_reg;
        pend_next      = 1'b0;
        rd_idx_next    = rd_idx_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        ridx_next      = ridx_reg;
        pot_next       = pot_reg;
        in_ready       = 1'b0;
        st_ctl         = '0;
        w_ctl          = '0;
        lbl_addr       = i_reg;
        val_addr       = i_reg;
        val_wdata      = w_result;

        // config writes; indexes past the list are dropped
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SIZE_X:      size_x_next = cfg_data;
                REG_SIZE_Y:      size_y_next = cfg_data;
                REG_SIZE_Z:      size_z_next = cfg_data;
                REG_SWEEP_COUNT: sweeps_next = cfg_data;
                REG_WEIGHT:      weight_next = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                lbl_addr = in_addr;
                val_addr = in_addr;
                val_wdata = start_value(voxel_label);
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_LOAD:
                        begin
                            st_ctl.lbl_we = idx_ok;
                            st_ctl.val_we = idx_ok;
                        end
                        OP_RUN:
                        begin
                            state_next = ST_SIZE_XY;
                        end
                        OP_READ:
                        begin
                            st_ctl.val_re = idx_ok;
                            rd_idx_next   = voxel_index;
                            rd_ok_next    = idx_ok;
                            state_next    = ST_RDATA;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RDATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = RK_READ;
                    ridx_next      = rd_idx_reg;
                    pot_next       = rd_ok_reg ? val_rdata : '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_SIZE_XY:
            begin
                sxy_next   = (2*CFGW)'(size_x_reg) * (2*CFGW)'(size_y_reg);
                state_next = ST_SIZE_XYZ;
            end
            ST_SIZE_XYZ:
            begin
                vol_next   = VW'(sxy_reg) * VW'(size_z_reg);
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                total_next = tot_new;
                state_next = ST_STRIDE;
            end
            ST_STRIDE:
            begin
                stride_next[0] = (total_reg < TW'(1)) ? total_reg : TW'(1);
                stride_next[1] = ((2*CFGW)'(size_x_reg) < (2*CFGW)'(total_reg))
                                 ? TW'(size_x_reg) : total_reg;
                stride_next[2] = (sxy_reg < (2*CFGW)'(total_reg))
                                 ? TW'(sxy_reg) : total_reg;
                sweep_next     = '0;
                i_next         = i_start;
                if ((total_reg < TW'(2)) || (sweeps_reg == '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LABEL;
                end
            end
            ST_LABEL:
            begin
                st_ctl.lbl_re = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (lbl_rdata == LBL_DOMAIN)
                begin
                    w_ctl.clear = 1'b1;
                    k_next      = '0;
                    state_next  = ST_NBR;
                end
                else
                begin
                    i_next     = adv_i;
                    sweep_next = adv_sweep;
                    state_next = adv_state;
                end
            end
            ST_NBR:
            begin
                val_addr      = nb_addr;
                st_ctl.val_re = nb_ok;
                pend_next     = nb_ok;
                w_ctl.add     = pend_reg;
                k_next        = k_reg + 3'd1;
                if (k_reg == 3'd5)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                w_ctl.add  = pend_reg;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                w_ctl.mul  = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                st_ctl.val_we = 1'b1;
                i_next        = adv_i;
                sweep_next    = adv_sweep;
                state_next    = adv_state;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = RK_DONE;
                    ridx_next      = '0;
                    pot_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_x_reg    <= SIZE_RST;
            size_y_reg    <= SIZE_RST;
            size_z_reg    <= SIZE_RST;
            sweeps_reg    <= SWEEP_RST;
            weight_reg    <= WEIGHT_RST;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_x_reg    <= size_x_next;
            size_y_reg    <= size_y_next;
            size_z_reg    <= size_z_next;
            sweeps_reg    <= sweeps_next;
            weight_reg    <= weight_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------------
    // Datapath registers (no reset)
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        sxy_reg    <= sxy_next;
        vol_reg    <= vol_next;
        total_reg  <= total_next;
        stride_reg <= stride_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        sweep_reg  <= sweep_next;
        rd_idx_reg <= rd_idx_next;
        rd_ok_reg  <= rd_ok_next;
        kind_reg   <= kind_next;
        ridx_reg   <= ridx_next;
        pot_reg    <= pot_next;
    end

    // ---------------------------------------------------------------------
    // Units
    // ---------------------------------------------------------------------
    lr3d_store #(
        .MAX_VOXELS (MAX_VOXELS),
        .AW         (AW)
    ) u_store (
        .clk       (clk),
        .ctl       (st_ctl),
        .lbl_addr  (lbl_addr),
        .lbl_wdata (voxel_label),
        .lbl_rdata (lbl_rdata),
        .val_addr  (val_addr),
        .val_wdata (val_wdata),
        .val_rdata (val_rdata)
    );

    lr3d_weigh u_weigh (
        .clk     (clk),
        .ctl     (w_ctl),
        .operand (val_rdata),
        .weight  (weight_reg),
        .result  (w_result)
    );

    // ---------------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------------
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign result_index = ridx_reg;
    assign potential    = pot_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // one value memory port: never a read and a write in the same cycle
    a_val_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_ctl.val_we && st_ctl.val_re))
        else $error("value memory read and write collide");

    // a pending neighbor read is only ever folded in during the gather
    a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_NBR || state_reg == ST_DRAIN))
        else $error("neighbor read pending outside gather");

    // sweep index always inside the volume
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LABEL) |-> (TW'(i_reg) < total_reg))
        else $error("sweep index beyond volume");

    // a new result never overwrites one that was not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(pot_reg)
                                           && $stable(kind_reg)))
        else $error("pending result overwritten");

    // no input transfer while a command is still being worked
    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> (state_reg == ST_IDLE))
        else $error("input taken while busy");

endmodule
